@@ rtl/core/best_fit_block_allocator_core_macros.svh @@
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-edge implication, sampled on clk, off while rst_n is low.
`define BFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication, sampled on clk, off while rst_n is low.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int ACT_W   = 2;
  localparam int REQ_W   = 32;
  localparam int HND_W   = 6;
  localparam int MIN_W   = 21;
  localparam int TOT_W   = 39;
  localparam int GRANT_W = 32;
  localparam int NEED_W  = REQ_W + 1;

  // remainder by the alignment: reciprocal multiply, then multiply back and subtract
  localparam int ROUND_STEPS  = 2;
  localparam int ROUND_CNT_W  = $clog2(ROUND_STEPS);
  localparam logic [ROUND_CNT_W-1:0] ROUND_LAST = ROUND_CNT_W'(ROUND_STEPS - 1);

  localparam logic [MIN_W-1:0] MIN_BLOCK_RESET = MIN_W'(4096);
  localparam logic [TOT_W-1:0] BYTE_CAP        = TOT_W'(64'd274877906944);

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ROUND,
    S_NEED,
    S_CHECK,
    S_SCAN,
    S_ALLOC,
    S_PEAK,
    S_FREE_CHK,
    S_SWEEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic round_step;
    logic need_calc;
    logic scan_start;
    logic scan_step;
    logic alloc_commit;
    logic peak_update;
    logic free_read;
    logic free_commit;
    logic sweep_step;
    logic release_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_release;
    logic req_zero;
    logic round_last;
    logic oversize;
    logic scan_done;
    logic sweep_done;
    logic out_free;
  } sts_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [REQ_W-1:0] b);
    logic [TOT_W-1:0] s;
    s = a + TOT_W'(b);
    return (s > BYTE_CAP) ? BYTE_CAP : s;
  endfunction

endpackage

@@ rtl/core/bfa_in_if.sv @@
`timescale 1ns / 1ps

interface bfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::ACT_W-1:0]   action;
  logic [bfa_pkg::REQ_W-1:0]   request_bytes;
  logic [bfa_pkg::HND_W-1:0]   block_handle;
  logic                        handle_is_null;

  modport source (
    output valid, action, request_bytes, block_handle, handle_is_null,
    input  ready
  );
  modport sink (
    input  valid, action, request_bytes, block_handle, handle_is_null,
    output ready
  );
endinterface

@@ rtl/core/bfa_out_if.sv @@
`timescale 1ns / 1ps

interface bfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bfa_pkg::HND_W-1:0]    granted_handle;
  logic                         made_new_block;
  logic [bfa_pkg::REQ_W-1:0]    granted_block_bytes;
  logic [bfa_pkg::TOT_W-1:0]    bytes_in_use;
  logic [bfa_pkg::TOT_W-1:0]    peak_bytes_in_use;
  logic [bfa_pkg::TOT_W-1:0]    bytes_reserved;
  logic [bfa_pkg::GRANT_W-1:0]  grants_made;

  modport source (
    output valid, status, granted_handle, made_new_block, granted_block_bytes,
           bytes_in_use, peak_bytes_in_use, bytes_reserved, grants_made,
    input  ready
  );
  modport sink (
    input  valid, status, granted_handle, made_new_block, granted_block_bytes,
           bytes_in_use, peak_bytes_in_use, bytes_reserved, grants_made,
    output ready
  );
endinterface

@@ rtl/core/bfa_ctrl.sv @@
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output bfa_pkg::cmd_t cmd,
  input  bfa_pkg::sts_t sts
);
  import bfa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_alloc) begin
          state_nxt = sts.req_zero ? S_DONE : S_ROUND;
        end else if (sts.is_free) begin
          cmd.free_read = 1'b1;
          state_nxt     = S_FREE_CHK;
        end else if (sts.is_release) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.round_last) begin
          state_nxt = S_NEED;
        end
      end
      S_NEED: begin
        cmd.need_calc = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        if (sts.oversize) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_ALLOC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_PEAK;
      end
      S_PEAK: begin
        cmd.peak_update = 1'b1;
        state_nxt       = S_DONE;
      end
      S_FREE_CHK: begin
        cmd.free_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_SWEEP: begin
        if (sts.sweep_done) begin
          cmd.release_commit = 1'b1;
          state_nxt          = S_DONE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bfa_dp.sv @@
`timescale 1ns / 1ps

module bfa_dp #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ALIGN_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bfa_pkg::cmd_t                cmd,
  output bfa_pkg::sts_t                sts,
  input  logic [bfa_pkg::ACT_W-1:0]    in_action,
  input  logic [bfa_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [bfa_pkg::HND_W-1:0]    in_block_handle,
  input  logic                         in_handle_is_null,
  input  logic                         cfg_wr_en,
  input  logic [bfa_pkg::MIN_W-1:0]    cfg_wr_data,
  bfa_out_if.source                    out_ch
);
  import bfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > HND_W) ? CNT_W : HND_W;
  localparam int RW    = $clog2(ALIGN_BYTES) + 1;
  localparam logic [RW-1:0]    ALIGN_R = RW'(ALIGN_BYTES);
  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_BLOCKS);
  // quotient = (req * RECIP) >> RSH, exact for every 32-bit request
  localparam int RSH = REQ_W + $clog2(ALIGN_BYTES);
  localparam logic [REQ_W:0] RECIP =
    (REQ_W + 1)'(((64'd1 << RSH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  // item capture
  logic [ACT_W-1:0]       action_r;
  logic [REQ_W-1:0]       req_r;
  logic [HND_W-1:0]       handle_r;
  logic                   null_r;

  // rounding
  logic [RW-1:0]          rem_r;
  logic [2*REQ_W:0]       prod;
  logic [REQ_W-1:0]       q_r;
  logic [ROUND_CNT_W-1:0] rnd_cnt_r;
  logic [NEED_W-1:0]      need_r;
  logic [RW-1:0]          pad;

  // table bookkeeping
  logic [MIN_W-1:0]       min_blk_r;
  logic [CNT_W-1:0]       created_r;
  logic [TOT_W-1:0]       reserved_r, used_r, peak_r;
  logic [GRANT_W-1:0]     grants_r;

  // scan
  logic [CNT_W-1:0]       scan_idx_r;
  logic                   idx_more;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [REQ_W-1:0]       best_cap_r;
  logic                   hit;

  // memories: capacity and {free, used bytes}
  logic [REQ_W-1:0]       cap_mem [MAX_BLOCKS];
  logic [REQ_W:0]         st_mem  [MAX_BLOCKS];
  logic [REQ_W-1:0]       cap_rd_r;
  logic [REQ_W:0]         st_rd_r;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       hidx;
  logic [IDX_W-1:0]       new_idx;
  logic                   cap_we;
  logic                   st_we;
  logic [IDX_W-1:0]       st_wa;
  logic [REQ_W:0]         st_wd;

  logic                   room;
  logic [REQ_W-1:0]       new_cap;
  logic                   free_ok;
  logic [TOT_W-1:0]       freed_bytes;

  // result
  status_t                res_status_r;
  logic [HND_W-1:0]       res_handle_r;
  logic                   res_new_r;
  logic [REQ_W-1:0]       res_bytes_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [HND_W-1:0]       out_handle_r;
  logic                   out_new_r;
  logic [REQ_W-1:0]       out_bytes_r;
  logic [TOT_W-1:0]       out_used_r, out_peak_r, out_reserved_r;
  logic [GRANT_W-1:0]     out_grants_r;

  assign hidx     = IDX_W'(handle_r);
  assign new_idx  = created_r[IDX_W-1:0];
  assign idx_more = scan_idx_r < created_r;
  assign room     = created_r < MAX_C;
  assign new_cap  = (need_r > NEED_W'(min_blk_r)) ? need_r[REQ_W-1:0] : REQ_W'(min_blk_r);
  assign free_ok  = !null_r && (CMP_W'(handle_r) < CMP_W'(created_r)) && !st_rd_r[REQ_W];
  assign freed_bytes = TOT_W'(st_rd_r[REQ_W-1:0]);
  assign pad      = (rem_r == '0) ? '0 : (ALIGN_R - rem_r);
  assign rd_addr  = cmd.free_read ? hidx : scan_idx_r[IDX_W-1:0];
  assign prod     = (2 * REQ_W + 1)'(req_r) * (2 * REQ_W + 1)'(RECIP);

  assign hit = cmp_vld_r && st_rd_r[REQ_W] && ({1'b0, cap_rd_r} >= need_r) &&
               (!found_r || (cap_rd_r < best_cap_r));

  always_comb begin
    sts.is_alloc   = (action_r == ACT_ALLOC);
    sts.is_free    = (action_r == ACT_FREE);
    sts.is_release = (action_r == ACT_RELEASE);
    sts.req_zero   = (req_r == '0);
    sts.round_last = (rnd_cnt_r == ROUND_LAST);
    sts.oversize   = need_r[NEED_W-1];
    sts.scan_done  = !idx_more && !cmp_vld_r;
    sts.sweep_done = !idx_more;
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  // single write port on the state memory
  always_comb begin
    st_we = 1'b0;
    st_wa = new_idx;
    st_wd = {1'b0, need_r[REQ_W-1:0]};
    if (cmd.alloc_commit && (found_r || room)) begin
      st_we = 1'b1;
      st_wa = found_r ? best_idx_r : new_idx;
    end else if (cmd.free_commit && free_ok) begin
      st_we = 1'b1;
      st_wa = hidx;
      st_wd = {1'b1, {REQ_W{1'b0}}};
    end else if (cmd.sweep_step && idx_more) begin
      st_we = 1'b1;
      st_wa = scan_idx_r[IDX_W-1:0];
      st_wd = {1'b1, {REQ_W{1'b0}}};
    end
    cap_we = cmd.alloc_commit && !found_r && room;
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[new_idx] <= new_cap;
    end
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    cap_rd_r <= cap_mem[rd_addr];
    st_rd_r  <= st_mem[rd_addr];
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r     <= in_action;
      req_r        <= in_request_bytes;
      handle_r     <= in_block_handle;
      null_r       <= in_handle_is_null;
      rem_r        <= '0;
      rnd_cnt_r    <= '0;
      res_status_r <= ((in_action == ACT_ALLOC) && (in_request_bytes == '0)) ?
                      STAT_ZERO : STAT_IGNORED;
      res_handle_r <= '0;
      res_new_r    <= 1'b0;
      res_bytes_r  <= '0;
    end
    // first step takes the quotient, second the remainder (below ALIGN, so RW bits do)
    if (cmd.round_step) begin
      if (rnd_cnt_r != ROUND_LAST) begin
        q_r <= REQ_W'(prod >> RSH);
      end else begin
        rem_r <= req_r[RW-1:0] - RW'(q_r[RW-1:0] * ALIGN_R);
      end
      rnd_cnt_r <= rnd_cnt_r + 1'b1;
    end
    if (cmd.need_calc) begin
      need_r <= NEED_W'(req_r) + NEED_W'(pad);
    end
    cmp_vld_r <= cmd.scan_step && idx_more;
    cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (hit) begin
      found_r    <= 1'b1;
      best_idx_r <= cmp_idx_r;
      best_cap_r <= cap_rd_r;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if ((cmd.scan_step || cmd.sweep_step) && idx_more) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.alloc_commit) begin
      if (found_r) begin
        res_status_r <= STAT_DONE;
        res_handle_r <= HND_W'(best_idx_r);
        res_bytes_r  <= best_cap_r;
      end else if (room) begin
        res_status_r <= STAT_DONE;
        res_handle_r <= HND_W'(new_idx);
        res_new_r    <= 1'b1;
        res_bytes_r  <= new_cap;
      end else begin
        res_status_r <= STAT_FULL;
      end
    end
    if ((cmd.free_commit && free_ok) || cmd.release_commit) begin
      res_status_r <= STAT_DONE;
    end
    if (cmd.out_load) begin
      out_status_r   <= res_status_r;
      out_handle_r   <= res_handle_r;
      out_new_r      <= res_new_r;
      out_bytes_r    <= res_bytes_r;
      out_used_r     <= used_r;
      out_peak_r     <= peak_r;
      out_reserved_r <= reserved_r;
      out_grants_r   <= grants_r;
    end
  end

  // bookkeeping state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_blk_r   <= MIN_BLOCK_RESET;
      created_r   <= '0;
      reserved_r  <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      grants_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_blk_r <= cfg_wr_data;
      end
      if (cmd.alloc_commit && (found_r || room)) begin
        used_r <= sat_add(used_r, need_r[REQ_W-1:0]);
        if (grants_r != '1) begin
          grants_r <= grants_r + 1'b1;
        end
        if (!found_r) begin
          created_r  <= created_r + 1'b1;
          reserved_r <= sat_add(reserved_r, new_cap);
        end
      end
      if (cmd.free_commit && free_ok) begin
        used_r <= (used_r > freed_bytes) ? (used_r - freed_bytes) : '0;
      end
      if (cmd.release_commit) begin
        used_r <= '0;
      end
      if (cmd.peak_update && (used_r > peak_r)) begin
        peak_r <= used_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = out_status_r;
  assign out_ch.granted_handle      = out_handle_r;
  assign out_ch.made_new_block      = out_new_r;
  assign out_ch.granted_block_bytes = out_bytes_r;
  assign out_ch.bytes_in_use        = out_used_r;
  assign out_ch.peak_bytes_in_use   = out_peak_r;
  assign out_ch.bytes_reserved      = out_reserved_r;
  assign out_ch.grants_made         = out_grants_r;

endmodule

@@ rtl/core/best_fit_block_allocator_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    action, request_bytes, block_handle, handle_is_null
// out_ch    out  valid/ready    status, grant fields, byte totals, grants_made
// cfg_*     in   cfg_wr_en      min_block_bytes (21 bits)
//
// One item at a time. Allocate: 2 rounding steps, the padded need, then the size check;
// the best-fit scan reads one entry a cycle and drains, then the grant and peak update.
// An oversize request skips the scan; zero size or an unknown action goes to the result.
// Deallocate reads the entry, then frees it; release all clears one entry a cycle.
// Synchronous active-low reset; the table needs no clearing pass after reset.
// The result waits in an output register; a stalled out_ch holds only the next result.
`include "best_fit_block_allocator_core_macros.svh"

module best_fit_block_allocator_core #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ALIGN_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bfa_in_if.sink                     in_ch,
  bfa_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [bfa_pkg::MIN_W-1:0]  cfg_wr_data
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ctrl_in_ready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_request_bytes  (in_ch.request_bytes),
    .in_block_handle   (in_ch.block_handle),
    .in_handle_is_null (in_ch.handle_is_null),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_ch            (out_ch)
  );

  assign in_ch.ready = ctrl_in_ready;

  `BFA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                   "item taken while busy")
  `BFA_ASSERT_SAME(a_peak_covers_use, out_ch.valid,
                   out_ch.peak_bytes_in_use >= out_ch.bytes_in_use,
                   "peak below bytes in use")
  `BFA_ASSERT_SAME(a_grant_fields_clear, out_ch.valid && (out_ch.status != STAT_DONE),
                   !out_ch.made_new_block && (out_ch.granted_block_bytes == '0) &&
                   (out_ch.granted_handle == '0), "grant fields set on failed item")
  `BFA_ASSERT_SAME(a_reserved_covers_use,
                   out_ch.valid && (out_ch.bytes_reserved != BYTE_CAP),
                   out_ch.bytes_reserved >= out_ch.bytes_in_use,
                   "reserved below bytes in use")

endmodule

@@ bench/best_fit_block_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module best_fit_block_allocator_core_tb;
  import bfa_pkg::*;

  localparam int MAX_ENTRIES = 64;
  localparam int ALIGN = 32;
  localparam int STALL_LIMIT = 4000;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [REQ_W-1:0] request_bytes;
    logic [HND_W-1:0] block_handle;
    logic             handle_is_null;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [HND_W-1:0]   granted_handle;
    logic               made_new_block;
    logic [REQ_W-1:0]   granted_block_bytes;
    logic [TOT_W-1:0]   bytes_in_use;
    logic [TOT_W-1:0]   peak_bytes_in_use;
    logic [TOT_W-1:0]   bytes_reserved;
    logic [GRANT_W-1:0] grants_made;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en;
  logic [MIN_W-1:0] cfg_wr_data;
  logic sink_ready = 1'b0;

  bfa_in_if in_ch ();
  bfa_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  best_fit_block_allocator_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator state as the block should hold it
  logic [REQ_W-1:0]   blk_cap [MAX_ENTRIES];
  logic [REQ_W-1:0]   blk_used [MAX_ENTRIES];
  bit                 blk_free [MAX_ENTRIES];
  int                 n_blocks;
  logic [TOT_W-1:0]   reserved_sum;
  logic [TOT_W-1:0]   in_use_sum;
  logic [TOT_W-1:0]   in_use_peak;
  logic [GRANT_W-1:0] grant_cnt;
  logic [MIN_W-1:0]   min_block;

  alloc_result_t pending_results[$];
  alloc_result_t last_prediction;
  int mismatches = 0;
  int idle_pct = 17;
  int stall_pct = 17;
  int quiet_cycles = 0;

  function automatic logic [TOT_W-1:0] add_capped(logic [TOT_W-1:0] a, logic [REQ_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + (TOT_W + 1)'(b);
    return (s > {1'b0, BYTE_CAP}) ? BYTE_CAP : s[TOT_W-1:0];
  endfunction

  function automatic alloc_result_t predict_allocator(request_t rq);
    alloc_result_t r;
    logic [REQ_W:0] need;
    logic [REQ_W:0] cap;
    int best;
    bit found;
    r = '0;
    r.status = STAT_IGNORED;
    case (rq.action)
      ACT_ALLOC: begin
        need = (({1'b0, rq.request_bytes} + (REQ_W + 1)'(ALIGN - 1)) / ALIGN) * ALIGN;
        if (rq.request_bytes == '0) begin
          r.status = STAT_ZERO;
        end else if (need[REQ_W]) begin
          r.status = STAT_IGNORED;
        end else begin
          found = 1'b0;
          best = 0;
          // smallest fitting free block; strict compare keeps the earliest on a tie
          for (int i = 0; i < n_blocks; i++) begin
            if (blk_free[i] && blk_cap[i] >= need[REQ_W-1:0] &&
                (!found || blk_cap[i] < blk_cap[best])) begin
              found = 1'b1;
              best = i;
            end
          end
          if (!found && n_blocks < MAX_ENTRIES) begin
            cap = (need > (REQ_W + 1)'(min_block)) ? need : (REQ_W + 1)'(min_block);
            best = n_blocks;
            blk_cap[best] = cap[REQ_W-1:0];
            n_blocks++;
            reserved_sum = add_capped(reserved_sum, cap[REQ_W-1:0]);
            found = 1'b1;
            r.made_new_block = 1'b1;
          end
          if (found) begin
            blk_free[best] = 1'b0;
            blk_used[best] = need[REQ_W-1:0];
            in_use_sum = add_capped(in_use_sum, need[REQ_W-1:0]);
            if (in_use_sum > in_use_peak) in_use_peak = in_use_sum;
            if (grant_cnt != '1) grant_cnt++;
            r.status = STAT_DONE;
            r.granted_handle = HND_W'(best);
            r.granted_block_bytes = blk_cap[best];
          end else begin
            r.status = STAT_FULL;
          end
        end
      end
      ACT_FREE: begin
        if (!rq.handle_is_null && int'(rq.block_handle) < n_blocks &&
            !blk_free[rq.block_handle]) begin
          in_use_sum = (in_use_sum > TOT_W'(blk_used[rq.block_handle])) ?
                       in_use_sum - TOT_W'(blk_used[rq.block_handle]) : '0;
          blk_used[rq.block_handle] = '0;
          blk_free[rq.block_handle] = 1'b1;
          r.status = STAT_DONE;
        end
      end
      ACT_RELEASE: begin
        for (int i = 0; i < n_blocks; i++) begin
          blk_free[i] = 1'b1;
          blk_used[i] = '0;
        end
        in_use_sum = '0;
        r.status = STAT_DONE;
      end
      default: r.status = STAT_IGNORED;
    endcase
    r.bytes_in_use = in_use_sum;
    r.peak_bytes_in_use = in_use_peak;
    r.bytes_reserved = reserved_sum;
    r.grants_made = grant_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding");
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        check_field("status", exp.status, out_ch.status);
        check_field("granted_handle", exp.granted_handle, out_ch.granted_handle);
        check_field("made_new_block", exp.made_new_block, out_ch.made_new_block);
        check_field("granted_block_bytes", exp.granted_block_bytes,
                    out_ch.granted_block_bytes);
        check_field("bytes_in_use", exp.bytes_in_use, out_ch.bytes_in_use);
        check_field("peak_bytes_in_use", exp.peak_bytes_in_use, out_ch.peak_bytes_in_use);
        check_field("bytes_reserved", exp.bytes_reserved, out_ch.bytes_reserved);
        check_field("grants_made", exp.grants_made, out_ch.grants_made);
      end
    end
  end

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles without any item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(request_t rq);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= rq.action;
    in_ch.request_bytes <= rq.request_bytes;
    in_ch.block_handle <= rq.block_handle;
    in_ch.handle_is_null <= rq.handle_is_null;
    do @(posedge clk); while (!in_ch.ready);
    last_prediction = predict_allocator(rq);
    pending_results = {pending_results, last_prediction};
  endtask

  // unused fields carry random values; the block must not look at them
  task automatic request_alloc(logic [REQ_W-1:0] bytes);
    send_request('{ACT_ALLOC, bytes, HND_W'($urandom), 1'($urandom)});
  endtask

  task automatic request_free(logic [HND_W-1:0] hnd, logic is_null);
    send_request('{ACT_FREE, $urandom, hnd, is_null});
  endtask

  task automatic request_release();
    send_request('{ACT_RELEASE, $urandom, HND_W'($urandom), 1'($urandom)});
  endtask

  task automatic request_unknown();
    send_request('{ACT_UNKNOWN, $urandom, HND_W'($urandom), 1'($urandom)});
  endtask

  task automatic write_min_block(logic [MIN_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_block = value;
  endtask

  function automatic int pick_live_handle();
    int live[$];
    for (int i = 0; i < n_blocks; i++) if (!blk_free[i]) live = {live, i};
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [REQ_W-1:0] random_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 4096);
    if (pick < 90) return $urandom_range(4097, 1 << 20);
    if (pick < 97) return $urandom_range(1, 64);
    return $urandom;
  endfunction

  task automatic test_special_requests();
    request_alloc('0);                 // zero size
    request_alloc(32'hFFFF_FFFF);      // aligned size overflows 32 bits
    request_alloc(32'hFFFF_FFE1);
    request_free(6'd0, 1'b1);          // null handle
    request_free(6'd63, 1'b0);         // handle never created
    request_unknown();
    request_alloc(32'd1);              // new block at the reset minimum
    request_alloc(32'd4096);
    request_alloc(32'hFFFF_FFE0);      // largest request that fits
    request_free(6'd0, 1'b0);
    request_free(6'd0, 1'b0);          // already free
    request_free(6'd1, 1'b0);
    request_alloc(32'd100);            // equal free blocks: earliest wins
    request_alloc(32'd5000);
    request_free(6'd2, 1'b0);
    request_alloc(32'd3000);           // best fit over the huge free block
    request_release();
    request_alloc(32'd33);
    request_free(6'd0, 1'b1);          // null flag on a live handle
    request_alloc(32'hFFFF_FFE0);
    request_release();
  endtask

  task automatic test_min_block_settings();
    logic [MIN_W-1:0] settings [6] = '{21'd32, 21'd1048576, 21'd0, 21'h1F_FFFF,
                                       21'd1000, 21'd4096};
    foreach (settings[k]) begin
      write_min_block(settings[k]);
      // use up free blocks until one has to be created
      do request_alloc($urandom_range(1, 96));
      while (!last_prediction.made_new_block && n_blocks < MAX_ENTRIES);
      request_alloc($urandom_range(1, 96));
    end
    request_release();
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    int hnd;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 52) begin
        request_alloc(random_size());
      end else if (pick < 84) begin
        hnd = pick_live_handle();
        if (hnd < 0) request_free(HND_W'($urandom), 1'b0);
        else request_free(HND_W'(hnd), 1'b0);
      end else if (pick < 87) begin
        request_release();
      end else begin
        case ($urandom_range(4))
          0: request_alloc('0);
          1: request_alloc(32'hFFFF_FFE1 + $urandom_range(30));
          2: request_free(HND_W'($urandom), 1'b1);
          3: request_free(HND_W'($urandom), 1'b0);
          default: request_unknown();
        endcase
      end
    end
  endtask

  task automatic test_table_full();
    int hnd;
    int guard = 0;
    do begin
      request_alloc(32'd32);
      guard++;
    end while (last_prediction.status != STAT_FULL && guard < 2 * MAX_ENTRIES);
    request_alloc(32'd1);
    request_alloc(32'hFFFF_FFE0);
    hnd = pick_live_handle();
    if (hnd >= 0) begin
      request_free(HND_W'(hnd), 1'b0);
      request_alloc(32'd1);
    end
    request_free(6'd63, 1'b0);
    request_release();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_ALLOC;
    in_ch.request_bytes <= '0;
    in_ch.block_handle <= '0;
    in_ch.handle_is_null <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      blk_cap[i] = '0;
      blk_used[i] = '0;
      blk_free[i] = 1'b0;
    end
    n_blocks = 0;
    reserved_sum = '0;
    in_use_sum = '0;
    in_use_peak = '0;
    grant_cnt = '0;
    min_block = MIN_BLOCK_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_requests();
    test_min_block_settings();
    test_random_traffic(600);
    write_min_block(21'd32);
    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(400);
    idle_pct = 17;
    stall_pct = 17;
    test_table_full();
    write_min_block(21'd65536);
    test_random_traffic(450);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
